/* sv/sevq_pkg.sv */
// Package for the sorted event queue: operation and status codes,
// the control bundle sent to every cell, and default sizes.
// No dependencies.
package sevq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int KIND_BITS_DEF = 8;

    localparam int OCC_BITS    = 5;
    localparam int STATUS_BITS = 2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

endpackage

/* sv/sevq_cell.sv */
// One slot of the sorted event queue chain: holds a time and a kind and
// shifts toward or away from the head. Depends on sevq_pkg.
module sevq_cell #(
    parameter int TIME_BITS = 32,
    parameter int KIND_BITS = 8
) (
    input  logic                  i_clk,
    input  sevq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_occupied,
    input  logic [TIME_BITS-1:0]  i_new_time,
    input  logic [KIND_BITS-1:0]  i_new_kind,
    input  logic                  i_left_gt,
    input  logic [TIME_BITS-1:0]  i_left_time,
    input  logic [KIND_BITS-1:0]  i_left_kind,
    input  logic [TIME_BITS-1:0]  i_right_time,
    input  logic [KIND_BITS-1:0]  i_right_kind,
    output logic                  o_gt,
    output logic [TIME_BITS-1:0]  o_time,
    output logic [KIND_BITS-1:0]  o_kind
);
    import sevq_pkg::*;

    logic [TIME_BITS-1:0] r_time, n_time;
    logic [KIND_BITS-1:0] r_kind, n_kind;

    // An empty slot counts as later than any time, so an insert lands at the
    // first free slot when no queued entry is later. Equal times stay ahead.
    assign o_gt = !i_occupied || (r_time > i_new_time);

    always_comb begin
        n_time = r_time;
        n_kind = r_kind;
        if (i_ctrl.ins && o_gt) begin
            if (i_left_gt) begin
                n_time = i_left_time;
                n_kind = i_left_kind;
            end else begin
                n_time = i_new_time;
                n_kind = i_new_kind;
            end
        end else if (i_ctrl.rem) begin
            n_time = i_right_time;
            n_kind = i_right_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_kind <= n_kind;
    end

    assign o_time = r_time;
    assign o_kind = r_kind;

endmodule

/* sv/sorted_event_queue_core.sv */
// Top level of the sorted event queue: stream ports, entry count, result
// register and the chain of sevq_cell slots. Depends on sevq_pkg, sevq_cell.
//
// A time-ordered event queue of up to DEPTH entries kept as a chain of slot
// cells, slot 0 being the head. An insert (tuser 0) places the event after all
// queued events of equal or smaller time; a remove (tuser 1) returns the head.
// Every transaction gives one result: status ok, empty (remove with nothing
// queued) or full (insert dropped), plus the removed kind and time (zero for
// other results) and the occupancy after the operation. One transaction is
// taken every clock cycle unless the output stalls; the registered result
// appears in the cycle after acceptance. The chain allows this rate: every
// cell compares its time with the incoming one in parallel and shifts by one
// place in the same cycle. The input stays ready while a result waits, as long
// as it is taken in that cycle. Slot contents need no clearing after reset.
module sorted_event_queue_core #(
    parameter int DEPTH     = sevq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = sevq_pkg::TIME_BITS_DEF,
    parameter int KIND_BITS = sevq_pkg::KIND_BITS_DEF,
    localparam int IN_W  = ((KIND_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((KIND_BITS + TIME_BITS + sevq_pkg::OCC_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // event_kind, event_time, zero padding
    input  logic [IN_W-1:0]                   s_axis_tdata,
    // func
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // head_kind, head_time, occupancy, zero padding
    output logic [OUT_W-1:0]                  m_axis_tdata,
    // status
    output logic [sevq_pkg::STATUS_BITS-1:0]  m_axis_tuser
);
    import sevq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 w_fire;
    logic                 w_func;
    logic [KIND_BITS-1:0] w_new_kind;
    logic [TIME_BITS-1:0] w_new_time;
    logic                 w_full, w_empty;
    t_cell_ctrl           w_ctrl;

    logic [CNT_W-1:0]     r_count, n_count;

    logic                 r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [KIND_BITS-1:0] r_out_kind;
    logic [TIME_BITS-1:0] r_out_time;
    logic [OCC_BITS-1:0]  r_out_occ;

    logic [TIME_BITS-1:0] w_time [DEPTH];
    logic [KIND_BITS-1:0] w_kind [DEPTH];
    logic [DEPTH-1:0]     w_gt;
    logic [DEPTH-1:0]     w_occ;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;
    assign w_func        = s_axis_tuser[0];
    assign w_new_kind    = s_axis_tdata[KIND_BITS-1:0];
    assign w_new_time    = s_axis_tdata[KIND_BITS+TIME_BITS-1:KIND_BITS];

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctrl.ins = w_fire && (w_func == FUNC_INSERT) && !w_full;
    assign w_ctrl.rem = w_fire && (w_func == FUNC_REMOVE) && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                 w_lgt;
            logic [TIME_BITS-1:0] w_ltime, w_rtime;
            logic [KIND_BITS-1:0] w_lkind, w_rkind;

            assign w_occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_lgt   = 1'b0;
                assign w_ltime = w_new_time;
                assign w_lkind = w_new_kind;
            end else begin : g_mid
                assign w_lgt   = w_gt[g-1];
                assign w_ltime = w_time[g-1];
                assign w_lkind = w_kind[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_rtime = w_time[g];
                assign w_rkind = w_kind[g];
            end else begin : g_body
                assign w_rtime = w_time[g+1];
                assign w_rkind = w_kind[g+1];
            end

            sevq_cell #(
                .TIME_BITS (TIME_BITS),
                .KIND_BITS (KIND_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_occupied   (w_occ[g]),
                .i_new_time   (w_new_time),
                .i_new_kind   (w_new_kind),
                .i_left_gt    (w_lgt),
                .i_left_time  (w_ltime),
                .i_left_kind  (w_lkind),
                .i_right_time (w_rtime),
                .i_right_kind (w_rkind),
                .o_gt         (w_gt[g]),
                .o_time       (w_time[g]),
                .o_kind       (w_kind[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_occ <= OCC_BITS'(n_count);
            if (w_ctrl.rem) begin
                r_out_status <= ST_OK;
                r_out_kind   <= w_kind[0];
                r_out_time   <= w_time[0];
            end else begin
                r_out_kind <= '0;
                r_out_time <= '0;
                if (w_func == FUNC_REMOVE) begin
                    r_out_status <= ST_EMPTY;
                end else if (w_full) begin
                    r_out_status <= ST_FULL;
                end else begin
                    r_out_status <= ST_OK;
                end
            end
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[KIND_BITS-1:0] = r_out_kind;
        m_axis_tdata[KIND_BITS+TIME_BITS-1:KIND_BITS] = r_out_time;
        m_axis_tdata[KIND_BITS+TIME_BITS+OCC_BITS-1:KIND_BITS+TIME_BITS] = r_out_occ;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // The two slots nearest the head stay in time order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_time[0] <= w_time[1]))
        else $error("head slots out of time order");

    // A remove that finds entries returns the head it saw.
    a_remove_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem |=> (r_out_valid && (r_out_status == ST_OK)
                        && (r_out_time == $past(w_time[0]))))
        else $error("removed head not reported");

    // An insert that finds every slot in use gives a full status and keeps the count at the depth.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_func == FUNC_INSERT) && w_full) |=>
            ((r_out_status == ST_FULL) && (r_count == CNT_W'(DEPTH))))
        else $error("full insert handled wrongly");

endmodule
